@@ rtl/wheel_odometry_pose_tracker_macros.svh @@
// assertion macros for the wheel odometry pose tracker
`ifndef WHEEL_ODOMETRY_POSE_TRACKER_MACROS_SVH
`define WHEEL_ODOMETRY_POSE_TRACKER_MACROS_SVH

// same-cycle implication
`define WOPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WOPT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wopt_pkg.sv @@
// types, codes and constants of the wheel odometry pose tracker
package wopt_pkg;

	localparam int TICK_WIDTH_DEF = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_DIST = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL = 1'b1;

	localparam logic [2:0] REQ_UPDATE      = 3'd0;
	localparam logic [2:0] REQ_SET_CELL    = 3'd1;
	localparam logic [2:0] REQ_SET_HEADING = 3'd2;
	localparam logic [2:0] REQ_FORCE_YAW   = 3'd3;
	localparam logic [2:0] REQ_RESTART     = 3'd4;

	localparam logic [1:0] HEAD_N = 2'd0;
	localparam logic [1:0] HEAD_E = 2'd1;
	localparam logic [1:0] HEAD_S = 2'd2;
	localparam logic [1:0] HEAD_W = 2'd3;

	localparam logic [23:0] DPT_RESET  = 24'd65536;
	localparam logic [9:0]  CELL_RESET = 10'd300;

	localparam logic [15:0] YAW_TURN = 16'd36000;
	localparam logic [15:0] YAW_Q1   = 16'd9000;
	localparam logic [15:0] YAW_Q2   = 16'd18000;
	localparam logic [15:0] YAW_Q3   = 16'd27000;
	localparam logic [15:0] YAW_O1   = 16'd4500;
	localparam logic [15:0] YAW_O3   = 16'd13500;
	localparam logic [15:0] YAW_O5   = 16'd22500;
	localparam logic [15:0] YAW_O7   = 16'd31500;
	localparam logic [13:0] QUARTER  = 14'd9000;
	localparam logic [13:0] OCTANT   = 14'd4500;

	localparam logic [17:0] RAD_PER_CDEG = 18'd187403;
	localparam logic [30:0] T_ONE        = 31'h4000_0000;
	localparam logic [16:0] OCT_ONE      = 17'd65536;
	localparam logic [47:0] MOVE_LIMIT   = 48'h0100_0000_0000;

	localparam logic [5:0] DIV_STEPS = 6'd32;

	localparam logic [2:0] SIN_FIRST = 3'd0;
	localparam logic [2:0] SIN_LAST  = 3'd2;
	localparam logic [2:0] COS_FIRST = 3'd3;
	localparam logic [2:0] COS_LAST  = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YAW,
		ST_DMUL,
		ST_XSQ,
		ST_PDIV,
		ST_PMUL,
		ST_SFIN,
		ST_PROJ,
		ST_PROJX,
		ST_PROJY,
		ST_CELLX,
		ST_CELLY,
		ST_DONE
	} wopt_state_t;

	// taylor term divisors, sine chain first then cosine chain
	function automatic logic [5:0] poly_divisor(input logic [2:0] step);
		logic [5:0] d;
		case (step)
			3'd0: d = 6'd42;
			3'd1: d = 6'd20;
			3'd2: d = 6'd6;
			3'd3: d = 6'd56;
			3'd4: d = 6'd30;
			3'd5: d = 6'd12;
			3'd6: d = 6'd2;
			default: d = 6'd1;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/wheel_odometry_pose_tracker.sv @@
// dead-reckoning pose tracker for a differential drive robot
// Every request returns one result with the pose after it. Set cell, set
// heading, force yaw, restart and unknown request types skip the arithmetic
// and go to the output register. An update whose counts did not move only
// reduces the yaw; one that moved also finds distance, position and cell:
// all products and quotients go one bit per cycle through one shift-add
// multiplier and one restoring divider, and the sine/cosine polynomials
// chain seven of each. A new request is taken once the previous one has
// reached the output register, even while that result still waits there.
`include "wheel_odometry_pose_tracker_macros.svh"

module wheel_odometry_pose_tracker #(
	parameter int TICK_WIDTH = wopt_pkg::TICK_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [wopt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wopt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       req_type,
	input  logic signed [31:0]               left_ticks,
	input  logic signed [31:0]               right_ticks,
	input  logic signed [23:0]               yaw_in,
	input  logic signed [7:0]                cell_x_in,
	input  logic signed [7:0]                cell_y_in,
	input  logic [1:0]                       heading_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               pos_x,
	output logic signed [31:0]               pos_y,
	output logic signed [7:0]                cell_x,
	output logic signed [7:0]                cell_y,
	output logic [1:0]                       heading,
	output logic signed [23:0]               yaw
);
	import wopt_pkg::*;

	wopt_state_t state_q, state_d;

	logic [23:0] dpt_q;
	logic [9:0] cs_q;
	logic [TICK_WIDTH-1:0] last_l_q, last_r_q;
	logic signed [31:0] px_q, py_q;
	logic [7:0] col_q, row_q;
	logic [1:0] compass_q;
	logic signed [23:0] yaw_q;

	logic signed [TICK_WIDTH:0] sum_q;
	logic moved_q;
	logic [15:0] a_q;
	logic [40:0] d_q;
	logic [29:0] x_q, x2_q;
	logic [1:0] quad_q;
	logic swap_q;
	logic [2:0] step_q;
	logic [16:0] sin_q, cos_q;

	logic [63:0] acc_q, mcand_q;
	logic [31:0] mplier_q;
	logic [31:0] dvd_q;
	logic [15:0] rem_q, dvs_q;
	logic [5:0] dcnt_q;

	logic out_valid_q;
	logic signed [31:0] ox_q, oy_q;
	logic [7:0] ocol_q, orow_q;
	logic [1:0] ohd_q;
	logic signed [23:0] oyaw_q;

	logic mul_go, div_go, mul_done, div_done, accept, out_load;
	logic [63:0] mul_a;
	logic [31:0] mul_b, div_n;
	logic [15:0] div_d;

	logic [TICK_WIDTH-1:0] dl, dr;
	logic signed [TICK_WIDTH:0] sum_in;
	logic [TICK_WIDTH:0] sum_mag;
	logic [23:0] yaw_in_mag;
	logic [15:0] a_n;
	logic [1:0] quad_n;
	logic [13:0] r_n;
	logic swap_n;
	logic [12:0] rp_n;
	logic [30:0] x_full;
	logic [29:0] x_n;
	logic [56:0] d_sum;
	logic [47:0] d_r;
	logic [40:0] d_n;
	logic [30:0] t_n;
	logic [31:0] cos_rnd, sin_rnd;
	logic [16:0] s0, c0, s_mag, c_mag;
	logic s_neg, c_neg, d_neg;
	logic [57:0] prj_rnd;
	logic [41:0] dm;
	logic signed [44:0] x_new, y_new;
	logic [31:0] px_abs, py_abs;
	logic [15:0] cs_eff;
	logic cell_neg;
	logic [7:0] cell_n;
	logic signed [26:0] cen_x, cen_y;
	logic [23:0] hd_yaw;
	logic [16:0] rem_sh;
	logic qbit;

	function automatic logic [1:0] heading_of(input logic [15:0] a);
		logic [1:0] h;
		if (a >= YAW_O7 || a < YAW_O1) begin
			h = HEAD_N;
		end else if (a < YAW_O3) begin
			h = HEAD_E;
		end else if (a < YAW_O5) begin
			h = HEAD_S;
		end else begin
			h = HEAD_W;
		end
		return h;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
		logic signed [31:0] r;
		if (v > 45'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -45'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign mul_done = (mplier_q == 32'd0);
	assign div_done = (dcnt_q == 6'd0);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign dl = left_ticks[TICK_WIDTH-1:0] - last_l_q;
	assign dr = right_ticks[TICK_WIDTH-1:0] - last_r_q;
	assign sum_in = $signed({dl[TICK_WIDTH-1], dl}) + $signed({dr[TICK_WIDTH-1], dr});
	assign sum_mag = sum_q[TICK_WIDTH] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign d_neg = sum_q[TICK_WIDTH];
	assign yaw_in_mag = yaw_in[23] ? $unsigned(-yaw_in) : $unsigned(yaw_in);

	assign a_n = (yaw_q[23] && rem_q != 16'd0) ? 16'(YAW_TURN - rem_q) : rem_q;

	always_comb begin
		if (a_q >= YAW_Q3) begin
			quad_n = 2'd3;
			r_n = 14'(a_q - YAW_Q3);
		end else if (a_q >= YAW_Q2) begin
			quad_n = 2'd2;
			r_n = 14'(a_q - YAW_Q2);
		end else if (a_q >= YAW_Q1) begin
			quad_n = 2'd1;
			r_n = 14'(a_q - YAW_Q1);
		end else begin
			quad_n = 2'd0;
			r_n = a_q[13:0];
		end
	end

	assign swap_n = (r_n > OCTANT);
	assign rp_n = swap_n ? 13'(QUARTER - r_n) : r_n[12:0];
	assign x_full = 31'(rp_n) * 31'(RAD_PER_CDEG);
	assign x_n = x_full[29:0];

	assign d_sum = acc_q[56:0] + 57'd256;
	assign d_r = d_sum[56:9];
	assign d_n = (d_r > MOVE_LIMIT) ? MOVE_LIMIT[40:0] : d_r[40:0];

	assign t_n = T_ONE - {1'b0, dvd_q[29:0]};
	assign cos_rnd = {1'b0, t_n} + 32'h2000;
	assign sin_rnd = {1'b0, acc_q[60:30]} + 32'h2000;

	assign s0 = swap_q ? cos_q : sin_q;
	assign c0 = swap_q ? sin_q : cos_q;

	always_comb begin
		case (quad_q)
			2'd0: begin
				s_mag = s0; s_neg = 1'b0; c_mag = c0; c_neg = 1'b0;
			end
			2'd1: begin
				s_mag = c0; s_neg = 1'b0; c_mag = s0; c_neg = 1'b1;
			end
			2'd2: begin
				s_mag = s0; s_neg = 1'b1; c_mag = c0; c_neg = 1'b1;
			end
			default: begin
				s_mag = c0; s_neg = 1'b1; c_mag = s0; c_neg = 1'b0;
			end
		endcase
	end

	assign prj_rnd = acc_q[57:0] + 58'h8000;
	assign dm = prj_rnd[57:16];
	assign x_new = (d_neg ^ s_neg) ? (45'(px_q) - $signed({3'b000, dm}))
	                               : (45'(px_q) + $signed({3'b000, dm}));
	assign y_new = (d_neg ^ c_neg) ? (45'(py_q) + $signed({3'b000, dm}))
	                               : (45'(py_q) - $signed({3'b000, dm}));

	assign px_abs = px_q[31] ? $unsigned(-px_q) : $unsigned(px_q);
	assign py_abs = py_q[31] ? $unsigned(-py_q) : $unsigned(py_q);
	assign cs_eff = (cs_q == 10'd0) ? 16'd1 : {6'b0, cs_q};
	assign cell_neg = (state_q == ST_CELLX) ? px_q[31] : py_q[31];
	assign cell_n = cell_neg ? (8'd0 - dvd_q[7:0]) : dvd_q[7:0];

	assign cen_x = $signed({{11{cell_x_in[7]}}, cell_x_in, 8'h80}) * $signed({11'b0, cs_eff});
	assign cen_y = $signed({{11{cell_y_in[7]}}, cell_y_in, 8'h80}) * $signed({11'b0, cs_eff});
	assign hd_yaw = 24'(heading_in) * 24'(QUARTER);

	assign rem_sh = {rem_q, dvd_q[31]};
	assign qbit = (rem_sh >= {1'b0, dvs_q});

	always_comb begin
		state_d = state_q;
		mul_go = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_go = 1'b0;
		div_n = '0;
		div_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_UPDATE) begin
						div_go = 1'b1;
						div_n = {8'b0, yaw_in_mag};
						div_d = YAW_TURN;
						state_d = ST_YAW;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_YAW: begin
				if (div_done) begin
					if (!moved_q) begin
						state_d = ST_DONE;
					end else begin
						mul_go = 1'b1;
						mul_a = 64'(sum_mag);
						mul_b = 32'(dpt_q);
						state_d = ST_DMUL;
					end
				end
			end
			ST_DMUL: begin
				if (mul_done) begin
					mul_go = 1'b1;
					mul_a = 64'(x_n);
					mul_b = 32'(x_n);
					state_d = ST_XSQ;
				end
			end
			ST_XSQ: begin
				if (mul_done) begin
					div_go = 1'b1;
					div_n = 32'(acc_q[59:30]);
					div_d = 16'(poly_divisor(SIN_FIRST));
					state_d = ST_PDIV;
				end
			end
			ST_PDIV: begin
				if (div_done) begin
					if (step_q == SIN_LAST) begin
						mul_go = 1'b1;
						mul_a = 64'(t_n);
						mul_b = 32'(x_q);
						state_d = ST_SFIN;
					end else if (step_q == COS_LAST) begin
						state_d = ST_PROJ;
					end else begin
						mul_go = 1'b1;
						mul_a = 64'(t_n);
						mul_b = 32'(x2_q);
						state_d = ST_PMUL;
					end
				end
			end
			ST_PMUL: begin
				if (mul_done) begin
					div_go = 1'b1;
					div_n = 32'(acc_q[59:30]);
					div_d = 16'(poly_divisor(3'(step_q + 3'd1)));
					state_d = ST_PDIV;
				end
			end
			ST_SFIN: begin
				if (mul_done) begin
					div_go = 1'b1;
					div_n = 32'(x2_q);
					div_d = 16'(poly_divisor(COS_FIRST));
					state_d = ST_PDIV;
				end
			end
			ST_PROJ: begin
				mul_go = 1'b1;
				mul_a = 64'(d_q);
				mul_b = 32'(s_mag);
				state_d = ST_PROJX;
			end
			ST_PROJX: begin
				if (mul_done) begin
					mul_go = 1'b1;
					mul_a = 64'(d_q);
					mul_b = 32'(c_mag);
					state_d = ST_PROJY;
				end
			end
			ST_PROJY: begin
				if (mul_done) begin
					div_go = 1'b1;
					div_n = {8'b0, px_abs[31:8]};
					div_d = cs_eff;
					state_d = ST_CELLX;
				end
			end
			ST_CELLX: begin
				if (div_done) begin
					div_go = 1'b1;
					div_n = {8'b0, py_abs[31:8]};
					div_d = cs_eff;
					state_d = ST_CELLY;
				end
			end
			ST_CELLY: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shift-add multiplier and restoring divider, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			mcand_q <= '0;
			mplier_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (mul_go) begin
				acc_q <= '0;
				mcand_q <= mul_a;
				mplier_q <= mul_b;
			end else if (!mul_done) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[62:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[31:1]};
			end
			if (div_go) begin
				dvd_q <= div_n;
				rem_q <= '0;
				dvs_q <= div_d;
				dcnt_q <= DIV_STEPS;
			end else if (!div_done) begin
				rem_q <= qbit ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
				dvd_q <= {dvd_q[30:0], qbit};
				dcnt_q <= dcnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= DPT_RESET;
			cs_q <= CELL_RESET;
			last_l_q <= '0;
			last_r_q <= '0;
			px_q <= '0;
			py_q <= '0;
			col_q <= '0;
			row_q <= '0;
			compass_q <= HEAD_N;
			yaw_q <= '0;
			sum_q <= '0;
			moved_q <= 1'b0;
			a_q <= '0;
			d_q <= '0;
			x_q <= '0;
			x2_q <= '0;
			quad_q <= '0;
			swap_q <= 1'b0;
			step_q <= '0;
			sin_q <= '0;
			cos_q <= '0;
			out_valid_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			ohd_q <= HEAD_N;
			oyaw_q <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DIST: dpt_q <= cfg_data;
					REG_CELL: cs_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_UPDATE: begin
								last_l_q <= left_ticks[TICK_WIDTH-1:0];
								last_r_q <= right_ticks[TICK_WIDTH-1:0];
								sum_q <= sum_in;
								moved_q <= (dl != '0) || (dr != '0);
								yaw_q <= yaw_in;
							end
							REQ_SET_CELL: begin
								col_q <= cell_x_in;
								row_q <= cell_y_in;
								px_q <= {{5{cen_x[26]}}, cen_x};
								py_q <= {{5{cen_y[26]}}, cen_y};
							end
							REQ_SET_HEADING: begin
								compass_q <= heading_in;
								yaw_q <= hd_yaw;
							end
							REQ_FORCE_YAW: begin
								yaw_q <= yaw_in;
							end
							REQ_RESTART: begin
								col_q <= cell_x_in;
								row_q <= cell_y_in;
								px_q <= {{5{cen_x[26]}}, cen_x};
								py_q <= {{5{cen_y[26]}}, cen_y};
								compass_q <= heading_in;
								yaw_q <= hd_yaw;
							end
							default: ;
						endcase
					end
				end
				ST_YAW: begin
					if (div_done) begin
						a_q <= a_n;
						compass_q <= heading_of(a_n);
					end
				end
				ST_DMUL: begin
					if (mul_done) begin
						d_q <= d_n;
						x_q <= x_n;
						quad_q <= quad_n;
						swap_q <= swap_n;
					end
				end
				ST_XSQ: begin
					if (mul_done) begin
						x2_q <= acc_q[59:30];
						step_q <= SIN_FIRST;
					end
				end
				ST_PDIV: begin
					if (div_done && step_q == COS_LAST) begin
						cos_q <= cos_rnd[30:14];
					end
				end
				ST_PMUL: begin
					if (mul_done) begin
						step_q <= 3'(step_q + 3'd1);
					end
				end
				ST_SFIN: begin
					if (mul_done) begin
						sin_q <= sin_rnd[30:14];
						step_q <= COS_FIRST;
					end
				end
				ST_PROJX: begin
					if (mul_done) begin
						px_q <= sat32(x_new);
					end
				end
				ST_PROJY: begin
					if (mul_done) begin
						py_q <= sat32(y_new);
					end
				end
				ST_CELLX: begin
					if (div_done) begin
						col_q <= cell_n;
					end
				end
				ST_CELLY: begin
					if (div_done) begin
						row_q <= cell_n;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						ox_q <= px_q;
						oy_q <= py_q;
						ocol_q <= col_q;
						orow_q <= row_q;
						ohd_q <= compass_q;
						oyaw_q <= yaw_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = ox_q;
	assign pos_y = oy_q;
	assign cell_x = ocol_q;
	assign cell_y = orow_q;
	assign heading = ohd_q;
	assign yaw = oyaw_q;

	`WOPT_ASSERT_NXT(a_short_req, accept && req_type != REQ_UPDATE, state_q == ST_DONE,
		"non-update request did not go straight to result")
	`WOPT_ASSERT_IMP(a_step_range, state_q == ST_PDIV, step_q <= COS_LAST,
		"polynomial step out of range")
	`WOPT_ASSERT_IMP(a_out_load, $rose(out_valid_q), $past(state_q == ST_DONE),
		"result shown without finished request")
	`WOPT_ASSERT_IMP(a_oct_range, state_q == ST_PROJ, sin_q <= OCT_ONE && cos_q <= OCT_ONE,
		"octant sine or cosine above one")

endmodule

@@ sim/wheel_odometry_pose_tracker_tb.sv @@
// testbench for the wheel odometry pose tracker: queued requests against a local pose predictor
module wheel_odometry_pose_tracker_tb;
	import wopt_pkg::*;

	typedef struct {
		logic [2:0] req;
		logic signed [31:0] lt;
		logic signed [31:0] rt;
		logic signed [23:0] yw;
		logic signed [7:0] cx;
		logic signed [7:0] cy;
		logic [1:0] hd;
	} pose_req_t;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [7:0] cx;
		logic signed [7:0] cy;
		logic [1:0] hd;
		logic signed [23:0] yw;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic signed [31:0] left_ticks = '0;
	logic signed [31:0] right_ticks = '0;
	logic signed [23:0] yaw_in = '0;
	logic signed [7:0] cell_x_in = '0;
	logic signed [7:0] cell_y_in = '0;
	logic [1:0] heading_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [7:0] cell_x;
	logic signed [7:0] cell_y;
	logic [1:0] heading;
	logic signed [23:0] yaw;

	wheel_odometry_pose_tracker uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pose_req_t pending_reqs[$];
	pose_t expected_poses[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int hold_marks = 0;
	int hold_taken = 0;

	// predictor state
	logic [23:0] m_dpt;
	logic [9:0] m_cell;
	logic [31:0] m_last_l, m_last_r;
	logic signed [31:0] m_px, m_py;
	logic signed [7:0] m_cx, m_cy;
	logic [1:0] m_hd;
	logic signed [23:0] m_yaw;

	function automatic longint rnd_shift(longint v, int k);
		longint unsigned m;
		longint unsigned r;
		m = v < 0 ? -v : v;
		r = (m + (64'd1 << (k - 1))) >> k;
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint taylor_sin(int r);
		longint unsigned x, x2, t;
		x = longint'(r) * 187403;
		x2 = (x * x) >> 30;
		t = (64'd1 << 30) - x2 / 42;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
		return longint'((((x * t) >> 30) + (1 << 13)) >> 14);
	endfunction

	function automatic longint taylor_cos(int r);
		longint unsigned x, x2, t;
		x = longint'(r) * 187403;
		x2 = (x * x) >> 30;
		t = (64'd1 << 30) - x2 / 56;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
		return longint'((t + (1 << 13)) >> 14);
	endfunction

	function automatic int cell_divisor();
		return m_cell == 0 ? 1 : int'(m_cell);
	endfunction

	function automatic logic signed [7:0] grid_of(logic signed [31:0] p);
		longint q;
		q = longint'(p) / (longint'(cell_divisor()) * 256);
		return q[7:0];
	endfunction

	task automatic place_at(logic signed [7:0] cx, logic signed [7:0] cy);
		int cs;
		int ix, iy;
		cs = cell_divisor();
		ix = int'(cx) * cs * 256 + cs * 128;
		iy = int'(cy) * cs * 256 + cs * 128;
		m_cx = cx;
		m_cy = cy;
		m_px = ix;
		m_py = iy;
	endtask

	task automatic predict_pose(pose_req_t q);
		longint dl, dr, d, s, c, s0, c0;
		int a, qd, r;
		pose_t e;
		logic [31:0] ddl, ddr;
		case (q.req)
			REQ_UPDATE: begin
				ddl = q.lt - m_last_l;
				ddr = q.rt - m_last_r;
				dl = longint'($signed(ddl));
				dr = longint'($signed(ddr));
				a = int'(q.yw) % 36000;
				if (a < 0) a += 36000;
				m_last_l = q.lt;
				m_last_r = q.rt;
				m_yaw = q.yw;
				if (a >= 31500 || a < 4500) m_hd = HEAD_N;
				else if (a < 13500) m_hd = HEAD_E;
				else if (a < 22500) m_hd = HEAD_S;
				else m_hd = HEAD_W;
				if (dl != 0 || dr != 0) begin
					d = rnd_shift((dl + dr) * longint'(m_dpt), 9);
					if (d > (64'sd1 <<< 40)) d = 64'sd1 <<< 40;
					if (d < -(64'sd1 <<< 40)) d = -(64'sd1 <<< 40);
					qd = a / 9000;
					r = a % 9000;
					if (r <= 4500) begin
						s0 = taylor_sin(r);
						c0 = taylor_cos(r);
					end else begin
						s0 = taylor_cos(9000 - r);
						c0 = taylor_sin(9000 - r);
					end
					case (qd)
						0: begin s = s0; c = c0; end
						1: begin s = c0; c = -s0; end
						2: begin s = -s0; c = -c0; end
						default: begin s = -c0; c = s0; end
					endcase
					m_px = clamp32(longint'(m_px) + rnd_shift(d * s, 16));
					m_py = clamp32(longint'(m_py) - rnd_shift(d * c, 16));
					m_cx = grid_of(m_px);
					m_cy = grid_of(m_py);
				end
			end
			REQ_SET_CELL: place_at(q.cx, q.cy);
			REQ_SET_HEADING: begin
				m_hd = q.hd;
				m_yaw = 24'(int'(q.hd) * 9000);
			end
			REQ_FORCE_YAW: m_yaw = q.yw;
			REQ_RESTART: begin
				place_at(q.cx, q.cy);
				m_hd = q.hd;
				m_yaw = 24'(int'(q.hd) * 9000);
			end
			default: ;
		endcase
		e.px = m_px;
		e.py = m_py;
		e.cx = m_cx;
		e.cy = m_cy;
		e.hd = m_hd;
		e.yw = m_yaw;
		expected_poses.push_back(e);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	logic accepted;
	assign accepted = in_valid && !in_stall;

	// an offered request was taken, or none was offered, at the last rising edge
	logic drop_done = 1'b1;
	always @(posedge clk) drop_done <= accepted || !in_valid;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && accepted) begin
			predict_pose(pending_reqs.pop_front());
		end
	end

	// driver
	always @(negedge clk) begin
		pose_req_t q;
		if (arst_n) begin
			if (!in_valid || drop_done) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					q = pending_reqs[0];
					in_valid <= 1'b1;
					req_type <= q.req;
					left_ticks <= q.lt;
					right_ticks <= q.rt;
					yaw_in <= q.yw;
					cell_x_in <= q.cx;
					cell_y_in <= q.cy;
					heading_in <= q.hd;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_marks != hold_taken) begin
				out_stall <= 1'b1;
				hold_off <= 3000;
				hold_taken <= hold_marks;
			end else if (hold_off > 0) begin
				out_stall <= 1'b1;
				hold_off <= hold_off - 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_poses.size() == 0) begin
				report("unexpected transfer", 0, 0);
			end else begin
				e = expected_poses.pop_front();
				if (pos_x !== e.px) report("pos_x", pos_x, e.px);
				if (pos_y !== e.py) report("pos_y", pos_y, e.py);
				if (cell_x !== e.cx) report("cell_x", cell_x, e.cx);
				if (cell_y !== e.cy) report("cell_y", cell_y, e.cy);
				if (heading !== e.hd) report("heading", heading, e.hd);
				if (yaw !== e.yw) report("yaw", yaw, e.yw);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 4000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic pose_req_t mk(logic [2:0] r, logic signed [31:0] l, logic signed [31:0] rr,
		logic signed [23:0] y, logic signed [7:0] cx, logic signed [7:0] cy, logic [1:0] h);
		pose_req_t q;
		q.req = r; q.lt = l; q.rt = rr; q.yw = y; q.cx = cx; q.cy = cy; q.hd = h;
		return q;
	endfunction

	function automatic pose_req_t rand_req(ref logic signed [31:0] l, ref logic signed [31:0] r);
		pose_req_t q;
		int k;
		q = mk(3'($urandom_range(4)), 0, 0, 24'($urandom), 8'($urandom), 8'($urandom),
			2'($urandom));
		k = $urandom_range(99);
		if (k < 70) begin
			q.req = REQ_UPDATE;
			if ($urandom_range(9) == 0) begin
				q.lt = l;
				q.rt = r;
			end else if ($urandom_range(9) == 0) begin
				q.lt = $urandom;
				q.rt = $urandom;
			end else begin
				q.lt = l + $signed($urandom_range(4000)) - 2000;
				q.rt = r + $signed($urandom_range(4000)) - 2000;
			end
			if ($urandom_range(3) == 0) q.yw = 24'($signed($urandom_range(72000)) - 36000);
			l = q.lt;
			r = q.rt;
		end else if (k < 73) begin
			q.req = 3'(3'd5 + $urandom_range(2));
		end
		return q;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_poses.size() > 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_DIST) m_dpt = v;
		else m_cell = v[9:0];
	endtask

	initial begin
		logic signed [31:0] lt, rt;
		int ph;
		m_dpt = DPT_RESET; m_cell = CELL_RESET;
		m_last_l = 0; m_last_r = 0; m_px = 0; m_py = 0;
		m_cx = 0; m_cy = 0; m_hd = HEAD_N; m_yaw = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed
		pending_reqs.push_back(mk(REQ_UPDATE, 100, 100, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_UPDATE, 100, 100, 9000, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_RESTART, 100, 100, 0, 127, -128, HEAD_W));
		pending_reqs.push_back(mk(REQ_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 24'sh7fffff, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_UPDATE, 32'sh80000000, 32'sh80000000, 24'sh800000,
			0, 0, 0));
		pending_reqs.push_back(mk(REQ_SET_CELL, 0, 0, 0, -128, 127, 0));
		pending_reqs.push_back(mk(REQ_SET_HEADING, 0, 0, 0, 0, 0, HEAD_S));
		pending_reqs.push_back(mk(REQ_FORCE_YAW, 0, 0, -4500, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_UPDATE, 5, -5, 13500, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_UPDATE, 32'sh7fffffff, 32'sh80000000, 31500, 0, 0, 0));
		pending_reqs.push_back(mk(3'd5, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_RESTART, 0, 0, 0, 0, 0, HEAD_E));
		pending_reqs.push_back(mk(REQ_UPDATE, 1000, 1000, 22500, 0, 0, 0));
		lt = 1000; rt = 1000;
		wait_drained();
		write_reg(REG_DIST, 24'hffffff);
		write_reg(REG_CELL, 24'd1);
		pending_reqs.push_back(mk(REQ_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 27000, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_UPDATE, -32'sd5, -32'sd5, 1, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_SET_CELL, 0, 0, 0, 127, -128, 0));
		lt = -5; rt = -5;
		wait_drained();
		write_reg(REG_CELL, 24'd0);
		pending_reqs.push_back(mk(REQ_SET_CELL, 0, 0, 0, 3, -3, 0));
		pending_reqs.push_back(mk(REQ_UPDATE, 300, 300, 100, 0, 0, 0));
		lt = 300; rt = 300;
		wait_drained();
		// random phases
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 69; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 69; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			case (ph)
				0: begin write_reg(REG_DIST, 24'd65536); write_reg(REG_CELL, 24'd300); end
				2: begin write_reg(REG_DIST, 24'd1); write_reg(REG_CELL, 24'd1023); end
				4: begin write_reg(REG_DIST, 24'($urandom)); write_reg(REG_CELL, 24'($urandom)); end
				6: begin write_reg(REG_DIST, 24'd4000000); write_reg(REG_CELL, 24'd17); end
				default: ;
			endcase
			if (ph == 1) hold_marks++;
			repeat (66) pending_reqs.push_back(rand_req(lt, rt));
			wait_drained();
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/wopt_pkg.sv
rtl/wheel_odometry_pose_tracker.sv
sim/wheel_odometry_pose_tracker_tb.sv
